@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the sphere vertex block.
// Expects signals named clock and reset in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define UVS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/uvs_pkg.sv @@
// Package of the UV-sphere vertex block: widths, register codes, CORDIC tables.
// No dependencies; every other file of the block but assert_macros.svh imports it.
`timescale 1ns / 1ps
`default_nettype none

package uvs_pkg;

   localparam int MAX_DIVISIONS_DEF = 64;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int IDX_W      = 7;
   localparam int CNT_REG_W  = 7;
   localparam int RADIUS_W   = 16;
   localparam int POS_W      = 17;
   localparam int TEX_W      = 17;
   localparam int TEX_FRAC   = 16;
   localparam int ANGLE_BITS = 24;
   localparam int QUO_W      = ANGLE_BITS + 1;
   localparam int CORDIC_W   = 33;
   localparam int ATAN_LEN   = 24;
   localparam int HALF_PI_W  = 31;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_REG_W-1:0] SLICE_COUNT_RST   = 7'd32;
   localparam logic [CNT_REG_W-1:0] STACK_COUNT_RST   = 7'd32;
   localparam logic [RADIUS_W-1:0]  SPHERE_RADIUS_RST = 16'd8192;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [HALF_PI_W-1:0]       HALF_PI_Q30 = 31'd1686629713;
   localparam logic [TEX_W-1:0]           TEX_ONE     = 17'd65536;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_SLICE_COUNT   = 2'd0,
      CSR_STACK_COUNT   = 2'd1,
      CSR_SPHERE_RADIUS = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quad_type;

   // Arctangent of 2^-stage in Q30, rounded to nearest.
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input int unsigned stage);
      logic signed [CORDIC_W-1:0] v;
      case (stage)
         0:  v = 33'sd843314857;
         1:  v = 33'sd497837829;
         2:  v = 33'sd263043837;
         3:  v = 33'sd133525159;
         4:  v = 33'sd67021687;
         5:  v = 33'sd33543516;
         6:  v = 33'sd16775851;
         7:  v = 33'sd8388437;
         8:  v = 33'sd4194283;
         9:  v = 33'sd2097149;
         10: v = 33'sd1048576;
         11: v = 33'sd524288;
         12: v = 33'sd262144;
         13: v = 33'sd131072;
         14: v = 33'sd65536;
         15: v = 33'sd32768;
         16: v = 33'sd16384;
         17: v = 33'sd8192;
         18: v = 33'sd4096;
         19: v = 33'sd2048;
         20: v = 33'sd1024;
         21: v = 33'sd512;
         22: v = 33'sd256;
         23: v = 33'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

@@ rtl/uvs_if.sv @@
// Valid/ready channel interfaces of the UV-sphere vertex block.
// Depends on uvs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface uvs_req_if
   import uvs_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] stack_index;
   logic [IDX_W-1:0] slice_index;

   modport source (output valid, output stack_index, output slice_index, input ready);
   modport sink   (input valid, input stack_index, input slice_index, output ready);
endinterface

interface uvs_rsp_if
   import uvs_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [POS_W-1:0] pos_z;
   logic [TEX_W-1:0]        tex_u;
   logic [TEX_W-1:0]        tex_v;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output tex_u, output tex_v, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input tex_u, input tex_v, output ready);
endinterface

`default_nettype wire

@@ rtl/uv_sphere_vertex_generator.sv @@
// Top level of the UV-sphere vertex block: registers, division and CORDIC rows, multipliers.
// Depends on uvs_pkg, uvs_if, uvs_div_cell, uvs_cordic_cell and assert_macros.svh.
//
//   channel  dir  handshake          payload
//   req      in   valid / ready      stack_index, slice_index
//   rsp      out  valid / ready      pos_x, pos_y, pos_z, tex_u, tex_v
//   csr      in   csr_write_enable   csr_index, csr_write_data
//
// One vertex enters per cycle while the pipeline is not held; the pipeline depth is set by
// the long-division row and the CORDIC row.
// Synchronous reset clears the valid bits and loads the register defaults.
// The whole pipeline holds while a result waits on rsp; an empty output slot lets it advance.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module uv_sphere_vertex_generator
   import uvs_pkg::*;
#(
   parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   uvs_req_if.sink               req,
   uvs_rsp_if.source             rsp,
   input  logic                  csr_write_enable,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int CNT_W    = $clog2(MAX_DIVISIONS + 1);
   localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;
   localparam int CORDIC_N = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
   localparam int LAT      = ANGLE_BITS + CORDIC_N + 7;
   localparam int REM_W    = ANGLE_BITS - 2;
   localparam int ZP_W     = REM_W + HALF_PI_W;
   localparam int SC_W     = CORDIC_W - 14;
   localparam int RS_W     = RADIUS_W + 1 + SC_W;
   localparam int XP_W     = RS_W + SC_W;
   localparam int XR_W     = XP_W - 32;
   localparam int ZR_W     = RS_W - 16;

   // configuration registers
   logic [CNT_REG_W-1:0] slice_count_ff;
   logic [CNT_REG_W-1:0] stack_count_ff;
   logic [RADIUS_W-1:0]  sphere_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_count_ff   <= SLICE_COUNT_RST;
         stack_count_ff   <= STACK_COUNT_RST;
         sphere_radius_ff <= SPHERE_RADIUS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SLICE_COUNT:   slice_count_ff   <= csr_write_data[CNT_REG_W-1:0];
            CSR_STACK_COUNT:   stack_count_ff   <= csr_write_data[CNT_REG_W-1:0];
            CSR_SPHERE_RADIUS: sphere_radius_ff <= csr_write_data[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_REG_W-1:0] c);
      logic [CMP_W-1:0] ext;
      logic [CMP_W-1:0] lim;
      logic [CMP_W-1:0] res;
      ext = CMP_W'(c);
      lim = CMP_W'(MAX_DIVISIONS);
      if (ext == '0) begin
         res = CMP_W'(1);
      end else if (ext > lim) begin
         res = lim;
      end else begin
         res = ext;
      end
      return res[CNT_W-1:0];
   endfunction

   logic [CNT_W-1:0] slices_eff, stacks_eff, slices_half, stacks_half;

   assign slices_eff  = eff_count(slice_count_ff);
   assign stacks_eff  = eff_count(stack_count_ff);
   assign slices_half = slices_eff >> 1;
   assign stacks_half = stacks_eff >> 1;

   // pipeline control
   logic [LAT-1:0] valid_ff, valid_in;
   logic           adv;

   assign adv      = !valid_ff[LAT-1] || rsp.ready;
   assign valid_in = {valid_ff[LAT-2:0], req.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   assign req.ready = adv;

   // clamp and integer quotient bit
   logic [CMP_W-1:0] slice_cl, stack_cl;
   logic             th_qbit, ph_qbit;
   logic [CNT_W-1:0] th_rem0_ff, th_rem0_in, ph_rem0_ff, ph_rem0_in;
   logic             th_q0_ff, ph_q0_ff;

   always_comb begin
      slice_cl = (CMP_W'(req.slice_index) > CMP_W'(slices_eff)) ?
                 CMP_W'(slices_eff) : CMP_W'(req.slice_index);
      stack_cl = (CMP_W'(req.stack_index) > CMP_W'(stacks_eff)) ?
                 CMP_W'(stacks_eff) : CMP_W'(req.stack_index);
      th_qbit    = slice_cl == CMP_W'(slices_eff);
      ph_qbit    = stack_cl == CMP_W'(stacks_eff);
      th_rem0_in = th_qbit ? '0 : slice_cl[CNT_W-1:0];
      ph_rem0_in = ph_qbit ? '0 : stack_cl[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         th_rem0_ff <= th_rem0_in;
         ph_rem0_ff <= ph_rem0_in;
         th_q0_ff   <= th_qbit;
         ph_q0_ff   <= ph_qbit;
      end
   end

   // long-division row: theta gets ANGLE_BITS fraction bits, phi one fewer
   logic [CNT_W-1:0] th_rem [0:ANGLE_BITS];
   logic [CNT_W-1:0] ph_rem [0:ANGLE_BITS];
   logic [QUO_W-1:0] th_quo [0:ANGLE_BITS];
   logic [QUO_W-1:0] ph_quo [0:ANGLE_BITS];
   logic [TEX_W-1:0] th_tex [0:ANGLE_BITS];
   logic [TEX_W-1:0] ph_tex [0:ANGLE_BITS];

   assign th_rem[0] = th_rem0_ff;
   assign ph_rem[0] = ph_rem0_ff;
   assign th_quo[0] = QUO_W'(th_q0_ff);
   assign ph_quo[0] = QUO_W'(ph_q0_ff);
   assign th_tex[0] = '0;
   assign ph_tex[0] = '0;

   for (genvar g = 1; g <= ANGLE_BITS; g++) begin : g_div
      uvs_div_cell #(.CNT_W(CNT_W), .STEP(g), .ACTIVE(1'b1)) u_th (
         .clock    (clock),
         .en       (adv),
         .divisor  (slices_eff),
         .half     (slices_half),
         .prev_rem (th_rem[g-1]),
         .prev_quo (th_quo[g-1]),
         .prev_tex (th_tex[g-1]),
         .rem      (th_rem[g]),
         .quo      (th_quo[g]),
         .tex      (th_tex[g])
      );
      uvs_div_cell #(.CNT_W(CNT_W), .STEP(g), .ACTIVE(g < ANGLE_BITS)) u_ph (
         .clock    (clock),
         .en       (adv),
         .divisor  (stacks_eff),
         .half     (stacks_half),
         .prev_rem (ph_rem[g-1]),
         .prev_quo (ph_quo[g-1]),
         .prev_tex (ph_tex[g-1]),
         .rem      (ph_rem[g]),
         .quo      (ph_quo[g]),
         .tex      (ph_tex[g])
      );
   end

   // round the angles; a full turn wraps to zero by dropping the top bit
   logic [ANGLE_BITS-1:0] ra_th_ff, ra_th_in, ra_ph_ff, ra_ph_in;
   logic [TEX_W-1:0]      ra_u_ff, ra_v_ff;
   logic [QUO_W-1:0]      th_round, ph_round;

   always_comb begin
      th_round = th_quo[ANGLE_BITS] + QUO_W'(({1'b0, th_rem[ANGLE_BITS]} +
                 {1'b0, slices_half}) >= {1'b0, slices_eff});
      ph_round = ph_quo[ANGLE_BITS] + QUO_W'(({1'b0, ph_rem[ANGLE_BITS]} +
                 {1'b0, stacks_half}) >= {1'b0, stacks_eff});
      ra_th_in = th_round[ANGLE_BITS-1:0];
      ra_ph_in = ph_round[ANGLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_th_ff <= ra_th_in;
         ra_ph_ff <= ra_ph_in;
         ra_u_ff  <= th_tex[ANGLE_BITS];
         ra_v_ff  <= ph_tex[ANGLE_BITS];
      end
   end

   // quadrant split and turn-to-radian scaling
   logic [ZP_W-1:0]            th_zprod, ph_zprod;
   logic signed [CORDIC_W-1:0] zm_th_z_ff, zm_ph_z_ff;
   quad_type                   zm_th_q_ff, zm_ph_q_ff;
   logic [TEX_W-1:0]           zm_u_ff, zm_v_ff;

   assign th_zprod = ZP_W'(ra_th_ff[REM_W-1:0]) * ZP_W'(HALF_PI_Q30);
   assign ph_zprod = ZP_W'(ra_ph_ff[REM_W-1:0]) * ZP_W'(HALF_PI_Q30);

   always_ff @(posedge clock) begin
      if (adv) begin
         zm_th_z_ff <= CORDIC_W'(th_zprod[ZP_W-1:REM_W]);
         zm_ph_z_ff <= CORDIC_W'(ph_zprod[ZP_W-1:REM_W]);
         zm_th_q_ff <= quad_type'(ra_th_ff[ANGLE_BITS-1:REM_W]);
         zm_ph_q_ff <= quad_type'(ra_ph_ff[ANGLE_BITS-1:REM_W]);
         zm_u_ff    <= ra_u_ff;
         zm_v_ff    <= ra_v_ff;
      end
   end

   // CORDIC row, one lane per angle
   logic signed [CORDIC_W-1:0] th_x [0:CORDIC_N];
   logic signed [CORDIC_W-1:0] th_y [0:CORDIC_N];
   logic signed [CORDIC_W-1:0] th_z [0:CORDIC_N];
   logic signed [CORDIC_W-1:0] ph_x [0:CORDIC_N];
   logic signed [CORDIC_W-1:0] ph_y [0:CORDIC_N];
   logic signed [CORDIC_W-1:0] ph_z [0:CORDIC_N];
   quad_type                   th_q [0:CORDIC_N];
   quad_type                   ph_q [0:CORDIC_N];
   logic [TEX_W-1:0]           th_t [0:CORDIC_N];
   logic [TEX_W-1:0]           ph_t [0:CORDIC_N];

   assign th_x[0] = CORDIC_GAIN;
   assign th_y[0] = '0;
   assign th_z[0] = zm_th_z_ff;
   assign th_q[0] = zm_th_q_ff;
   assign th_t[0] = zm_u_ff;
   assign ph_x[0] = CORDIC_GAIN;
   assign ph_y[0] = '0;
   assign ph_z[0] = zm_ph_z_ff;
   assign ph_q[0] = zm_ph_q_ff;
   assign ph_t[0] = zm_v_ff;

   for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
      uvs_cordic_cell #(.STAGE(k)) u_th (
         .clock     (clock),
         .en        (adv),
         .prev_x    (th_x[k]),
         .prev_y    (th_y[k]),
         .prev_z    (th_z[k]),
         .prev_quad (th_q[k]),
         .prev_tag  (th_t[k]),
         .x         (th_x[k+1]),
         .y         (th_y[k+1]),
         .z         (th_z[k+1]),
         .quad      (th_q[k+1]),
         .tag       (th_t[k+1])
      );
      uvs_cordic_cell #(.STAGE(k)) u_ph (
         .clock     (clock),
         .en        (adv),
         .prev_x    (ph_x[k]),
         .prev_y    (ph_y[k]),
         .prev_z    (ph_z[k]),
         .prev_quad (ph_q[k]),
         .prev_tag  (ph_t[k]),
         .x         (ph_x[k+1]),
         .y         (ph_y[k+1]),
         .z         (ph_z[k+1]),
         .quad      (ph_q[k+1]),
         .tag       (ph_t[k+1])
      );
   end

   // apply quadrant and round Q30 to Q16
   function automatic logic signed [SC_W-1:0] to_q16(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W-1:0] sum;
      sum = v + CORDIC_W'(1 << 13);
      return sum[CORDIC_W-1:14];
   endfunction

   logic signed [CORDIC_W-1:0] th_c, th_s, ph_c, ph_s;
   logic signed [SC_W-1:0]     sc_ct_ff, sc_st_ff, sc_cp_ff, sc_sp_ff;
   logic [TEX_W-1:0]           sc_u_ff, sc_v_ff;

   always_comb begin
      unique case (th_q[CORDIC_N])
         QUAD_FIRST:  begin th_c = th_x[CORDIC_N];  th_s = th_y[CORDIC_N];  end
         QUAD_SECOND: begin th_c = -th_y[CORDIC_N]; th_s = th_x[CORDIC_N];  end
         QUAD_THIRD:  begin th_c = -th_x[CORDIC_N]; th_s = -th_y[CORDIC_N]; end
         default:     begin th_c = th_y[CORDIC_N];  th_s = -th_x[CORDIC_N]; end
      endcase
      unique case (ph_q[CORDIC_N])
         QUAD_FIRST:  begin ph_c = ph_x[CORDIC_N];  ph_s = ph_y[CORDIC_N];  end
         QUAD_SECOND: begin ph_c = -ph_y[CORDIC_N]; ph_s = ph_x[CORDIC_N];  end
         QUAD_THIRD:  begin ph_c = -ph_x[CORDIC_N]; ph_s = -ph_y[CORDIC_N]; end
         default:     begin ph_c = ph_y[CORDIC_N];  ph_s = -ph_x[CORDIC_N]; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sc_ct_ff <= to_q16(th_c);
         sc_st_ff <= to_q16(th_s);
         sc_cp_ff <= to_q16(ph_c);
         sc_sp_ff <= to_q16(ph_s);
         sc_u_ff  <= th_t[CORDIC_N];
         sc_v_ff  <= ph_t[CORDIC_N];
      end
   end

   // radius products
   logic signed [RADIUS_W:0]   radius_s;
   logic signed [RS_W-1:0]     m1_rs_ff, m1_zp_ff;
   logic signed [SC_W-1:0]     m1_ct_ff, m1_st_ff;
   logic [TEX_W-1:0]           m1_u_ff, m1_v_ff;

   assign radius_s = $signed({1'b0, sphere_radius_ff});

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_rs_ff <= RS_W'(radius_s * sc_sp_ff);
         m1_zp_ff <= RS_W'(radius_s * sc_cp_ff);
         m1_ct_ff <= sc_ct_ff;
         m1_st_ff <= sc_st_ff;
         m1_u_ff  <= sc_u_ff;
         m1_v_ff  <= sc_v_ff;
      end
   end

   logic signed [XP_W-1:0] m2_xp_ff, m2_yp_ff;
   logic signed [RS_W-1:0] m2_zp_ff;
   logic [TEX_W-1:0]       m2_u_ff, m2_v_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         m2_xp_ff <= XP_W'(m1_rs_ff * m1_ct_ff);
         m2_yp_ff <= XP_W'(m1_rs_ff * m1_st_ff);
         m2_zp_ff <= m1_zp_ff;
         m2_u_ff  <= m1_u_ff;
         m2_v_ff  <= m1_v_ff;
      end
   end

   // round, saturate and hold the result
   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [XR_W-1:0] v);
      logic fits;
      fits = (v[XR_W-1:POS_W-1] == '0) || (v[XR_W-1:POS_W-1] == '1);
      if (fits) begin
         return v[POS_W-1:0];
      end else if (v[XR_W-1]) begin
         return {1'b1, {(POS_W-1){1'b0}}};
      end else begin
         return {1'b0, {(POS_W-1){1'b1}}};
      end
   endfunction

   logic signed [XP_W-1:0]  xr_sum, yr_sum;
   logic signed [RS_W-1:0]  zr_sum;
   logic signed [XR_W-1:0]  z_ext;
   logic signed [ZR_W-1:0]  z_round;

   always_comb begin
      xr_sum  = m2_xp_ff + XP_W'(64'h8000_0000);
      yr_sum  = m2_yp_ff + XP_W'(64'h8000_0000);
      zr_sum  = m2_zp_ff + RS_W'(1 << 15);
      z_round = zr_sum[RS_W-1:16];
      z_ext   = XR_W'(z_round);
   end

   logic signed [POS_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_pos_z_ff;
   logic [TEX_W-1:0]        rsp_tex_u_ff, rsp_tex_v_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_pos_x_ff <= sat_pos(xr_sum[XP_W-1:32]);
         rsp_pos_y_ff <= sat_pos(yr_sum[XP_W-1:32]);
         rsp_pos_z_ff <= sat_pos(z_ext);
         rsp_tex_u_ff <= m2_u_ff;
         rsp_tex_v_ff <= m2_v_ff;
      end
   end

   assign rsp.valid = valid_ff[LAT-1];
   assign rsp.pos_x = rsp_pos_x_ff;
   assign rsp.pos_y = rsp_pos_y_ff;
   assign rsp.pos_z = rsp_pos_z_ff;
   assign rsp.tex_u = rsp_tex_u_ff;
   assign rsp.tex_v = rsp_tex_v_ff;

   `UVS_ASSERT_IMPLY(a_tex_range, rsp.valid, (rsp.tex_u <= TEX_ONE) && (rsp.tex_v <= TEX_ONE), "texture coordinate above one")
   `UVS_ASSERT_IMPLY(a_count_nonzero, 1'b1, (slices_eff != '0) && (stacks_eff != '0), "effective count is zero")
   `UVS_ASSERT_NEXT(a_stall_hold, !adv, $stable(valid_ff) && $stable(rsp_pos_x_ff), "pipeline moved during a stall")

endmodule

`default_nettype wire

@@ rtl/uvs_div_cell.sv @@
// One restoring long-division cell: produces one fraction bit of index/count
// when ACTIVE. Depends on uvs_pkg; instantiated in a row by the top level.
`timescale 1ns / 1ps
`default_nettype none

module uvs_div_cell
   import uvs_pkg::*;
#(
   parameter int CNT_W  = 7,
   parameter int STEP   = 1,
   parameter bit ACTIVE = 1'b1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [CNT_W-1:0] divisor,
   input  logic [CNT_W-1:0] half,
   input  logic [CNT_W-1:0] prev_rem,
   input  logic [QUO_W-1:0] prev_quo,
   input  logic [TEX_W-1:0] prev_tex,
   output logic [CNT_W-1:0] rem,
   output logic [QUO_W-1:0] quo,
   output logic [TEX_W-1:0] tex
);

   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [TEX_W-1:0] tex_ff, tex_in;
   logic [CNT_W:0]   rem2;
   logic [CNT_W:0]   diff;
   logic             ge;
   logic             round_up;

   always_comb begin
      rem2 = {prev_rem, 1'b0};
      ge   = rem2 >= {1'b0, divisor};
      diff = rem2 - {1'b0, divisor};
      if (ACTIVE) begin
         rem_in = ge ? diff[CNT_W-1:0] : rem2[CNT_W-1:0];
         quo_in = {prev_quo[QUO_W-2:0], ge};
      end else begin
         rem_in = prev_rem;
         quo_in = prev_quo;
      end
      // round half up: bump when remainder plus half a count reaches the count
      round_up = ({1'b0, rem_in} + {1'b0, half}) >= {1'b0, divisor};
      if (STEP == TEX_FRAC) begin
         tex_in = quo_in[TEX_W-1:0] + TEX_W'(round_up);
      end else begin
         tex_in = prev_tex;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         tex_ff <= tex_in;
      end
   end

   assign rem = rem_ff;
   assign quo = quo_ff;
   assign tex = tex_ff;

endmodule

`default_nettype wire

@@ rtl/uvs_cordic_cell.sv @@
// One CORDIC rotation cell in Q30, carrying the quadrant and a side tag along.
// Depends on uvs_pkg for the arctangent table and widths.
`timescale 1ns / 1ps
`default_nettype none

module uvs_cordic_cell
   import uvs_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic                       clock,
   input  logic                       en,
   input  logic signed [CORDIC_W-1:0] prev_x,
   input  logic signed [CORDIC_W-1:0] prev_y,
   input  logic signed [CORDIC_W-1:0] prev_z,
   input  quad_type                   prev_quad,
   input  logic [TEX_W-1:0]           prev_tag,
   output logic signed [CORDIC_W-1:0] x,
   output logic signed [CORDIC_W-1:0] y,
   output logic signed [CORDIC_W-1:0] z,
   output quad_type                   quad,
   output logic [TEX_W-1:0]           tag
);

   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   quad_type                   quad_ff;
   logic [TEX_W-1:0]           tag_ff;
   logic signed [CORDIC_W-1:0] dx;
   logic signed [CORDIC_W-1:0] dy;
   logic signed [CORDIC_W-1:0] step_angle;

   always_comb begin
      dx         = prev_y >>> STAGE;
      dy         = prev_x >>> STAGE;
      step_angle = atan_q30(STAGE);
      // rotate towards zero residual angle
      if (!prev_z[CORDIC_W-1]) begin
         x_in = prev_x - dx;
         y_in = prev_y + dy;
         z_in = prev_z - step_angle;
      end else begin
         x_in = prev_x + dx;
         y_in = prev_y - dy;
         z_in = prev_z + step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         quad_ff <= prev_quad;
         tag_ff  <= prev_tag;
      end
   end

   assign x    = x_ff;
   assign y    = y_ff;
   assign z    = z_ff;
   assign quad = quad_ff;
   assign tag  = tag_ff;

endmodule

`default_nettype wire

@@ test/uv_sphere_vertex_generator_tb.sv @@
// Self-checking testbench of uv_sphere_vertex_generator: directed vertices, count and radius
// settings, random index pairs under random idling and back-pressure, each checked in order.
// Depends on uvs_pkg and the channel interfaces in uvs_if.
`timescale 1ns / 1ps

module uv_sphere_vertex_generator_tb;
   import uvs_pkg::*;

   typedef struct {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [TEX_W-1:0]        tex_u;
      logic [TEX_W-1:0]        tex_v;
   } vertex_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED = 2'd3;
   localparam int  PIPE_LATENCY   = ANGLE_BITS + CORDIC_STAGES_DEF + 7;
   localparam int  WATCHDOG_LIMIT = 4000;
   localparam int  IDLE_PERCENT   = 29;
   localparam longint ARCTAN_Q30 [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

   logic clock;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   uvs_req_if req_if ();
   uvs_rsp_if rsp_if ();

   uv_sphere_vertex_generator u_top (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if.sink),
      .rsp              (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow copy of the registers
   logic [CNT_REG_W-1:0] slice_count_reg;
   logic [CNT_REG_W-1:0] stack_count_reg;
   logic [RADIUS_W-1:0]  radius_reg;

   vertex_type expected_vertices[$];
   int  mismatch_count;
   int  quiet_cycles;
   int  ready_hold_left;
   bit  no_idle;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint effective_count(input logic [CNT_REG_W-1:0] c);
      if (c == 0) return 1;
      if (c > 64) return 64;
      return longint'(c);
   endfunction

   // Sine and cosine in Q16 of an angle in 2^-24 turns.
   task automatic turn_sincos(input logic [ANGLE_BITS-1:0] turn,
                              output longint s_q16, output longint c_q16);
      logic [1:0] quad;
      longint rem, x, y, z, dx, dy, s, c;
      quad = turn[ANGLE_BITS-1 -: 2];
      rem = longint'(turn[ANGLE_BITS-3:0]);
      z = (rem * 64'd1686629713) >> (ANGLE_BITS - 2);
      x = 652032874;
      y = 0;
      for (int i = 0; i < CORDIC_STAGES_DEF && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN_Q30[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN_Q30[i];
         end
      end
      case (quad_type'(quad))
         QUAD_FIRST:  begin c = x;  s = y;  end
         QUAD_SECOND: begin c = -y; s = x;  end
         QUAD_THIRD:  begin c = -x; s = -y; end
         default:     begin c = y;  s = -x; end
      endcase
      s_q16 = (s + (1 << 13)) >>> 14;
      c_q16 = (c + (1 << 13)) >>> 14;
   endtask

   function automatic logic [POS_W-1:0] saturate_pos(input longint v);
      if (v < -65536) v = -65536;
      if (v > 65535) v = 65535;
      return v[POS_W-1:0];
   endfunction

   task automatic predict_vertex(input logic [IDX_W-1:0] stack_in,
                                 input logic [IDX_W-1:0] slice_in, output vertex_type v);
      longint slices, stacks, stack, slice, theta, phi, st, ct, sp, cp, r, rs, u, w;
      slices = effective_count(slice_count_reg);
      stacks = effective_count(stack_count_reg);
      stack = longint'(stack_in);
      slice = longint'(slice_in);
      if (stack > stacks) stack = stacks;
      if (slice > slices) slice = slices;
      theta = ((slice << ANGLE_BITS) + slices / 2) / slices;
      phi = ((stack << (ANGLE_BITS - 1)) + stacks / 2) / stacks;
      // a full turn wraps to zero through the 24-bit truncation
      turn_sincos(theta[ANGLE_BITS-1:0], st, ct);
      turn_sincos(phi[ANGLE_BITS-1:0], sp, cp);
      r = longint'(radius_reg);
      rs = r * sp;
      v.pos_x = saturate_pos((rs * ct + (64'sd1 << 31)) >>> 32);
      v.pos_y = saturate_pos((rs * st + (64'sd1 << 31)) >>> 32);
      v.pos_z = saturate_pos((r * cp + (64'sd1 << 15)) >>> 16);
      u = ((slice << 16) + slices / 2) / slices;
      w = ((stack << 16) + stacks / 2) / stacks;
      v.tex_u = u[TEX_W-1:0];
      v.tex_v = w[TEX_W-1:0];
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Result receiver: random idling, long holds on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (ready_hold_left > 0) begin
         ready_hold_left <= ready_hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      vertex_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_vertices.size() == 0) begin
            report_mismatch("result with no vertex pending", 1, 0);
         end else begin
            want = expected_vertices.pop_front();
            if (rsp_if.pos_x !== want.pos_x) report_mismatch("pos_x", rsp_if.pos_x, want.pos_x);
            if (rsp_if.pos_y !== want.pos_y) report_mismatch("pos_y", rsp_if.pos_y, want.pos_y);
            if (rsp_if.pos_z !== want.pos_z) report_mismatch("pos_z", rsp_if.pos_z, want.pos_z);
            if (rsp_if.tex_u !== want.tex_u) report_mismatch("tex_u", rsp_if.tex_u, want.tex_u);
            if (rsp_if.tex_v !== want.tex_v) report_mismatch("tex_v", rsp_if.tex_v, want.tex_v);
         end
      end
   end

   // Watchdog on cycles with no transfer while an item is offered or outstanding
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (expected_vertices.size() == 0 && !req_if.valid)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_vertex(input int stack_in, input int slice_in);
      vertex_type v;
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.stack_index <= IDX_W'(stack_in);
      req_if.slice_index <= IDX_W'(slice_in);
      do @(posedge clock); while (!req_if.ready);
      predict_vertex(IDX_W'(stack_in), IDX_W'(slice_in), v);
      expected_vertices.push_back(v);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_SLICE_COUNT:   slice_count_reg = data[CNT_REG_W-1:0];
         CSR_STACK_COUNT:   stack_count_reg = data[CNT_REG_W-1:0];
         CSR_SPHERE_RADIUS: radius_reg = data;
         default: ;
      endcase
   endtask

   task automatic set_sphere(input int slices, input int stacks, input int radius);
      wait_drained();
      write_register(CSR_SLICE_COUNT, CSR_DATA_W'(slices));
      write_register(CSR_STACK_COUNT, CSR_DATA_W'(stacks));
      write_register(CSR_SPHERE_RADIUS, CSR_DATA_W'(radius));
   endtask

   task automatic test_reset_defaults();
      send_vertex(0, 0);
      send_vertex(32, 32);
      send_vertex(16, 8);
      send_vertex(8, 24);
      send_vertex(127, 127);
      send_vertex(64, 0);
      send_vertex(0, 64);
      send_vertex(85, 42);
      send_vertex(42, 85);
      send_vertex(31, 1);
   endtask

   task automatic test_register_extremes();
      set_sphere(1, 1, 0);
      send_vertex(0, 0);
      send_vertex(1, 1);
      send_vertex(127, 127);
      set_sphere(64, 64, 65535);
      send_vertex(32, 16);
      send_vertex(64, 64);
      send_vertex(16, 48);
      send_vertex(0, 0);
      set_sphere(0, 0, 65535);
      send_vertex(1, 0);
      send_vertex(0, 1);
      set_sphere(127, 100, 16384);
      send_vertex(100, 127);
      send_vertex(65, 3);
      send_vertex(21, 63);
      // a write to an index beyond the registers changes nothing
      wait_drained();
      write_register(CSR_UNUSED, 16'hFFFF);
      send_vertex(10, 20);
   endtask

   task automatic random_vertex();
      int slices, stacks;
      slices = int'(effective_count(slice_count_reg));
      stacks = int'(effective_count(stack_count_reg));
      if ($urandom_range(9) == 0)
         send_vertex($urandom_range(127), $urandom_range(127));
      else
         send_vertex($urandom_range(stacks + 1), $urandom_range(slices + 1));
   endtask

   task automatic test_random_spheres();
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(3))
            0: set_sphere($urandom_range(127), $urandom_range(127), $urandom);
            1: set_sphere($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(65535));
            default: set_sphere($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(65535));
         endcase
         no_idle = (phase == 3);
         repeat (200) random_vertex();
      end
      no_idle = 1'b0;
   endtask

   task automatic test_backpressure();
      set_sphere(48, 24, 40000);
      no_idle = 1'b1;
      ready_hold_left = 250;
      repeat (150) random_vertex();
      no_idle = 1'b0;
      // let every result come home before offering more
      req_if.valid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (40) random_vertex();
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.stack_index = '0;
      req_if.slice_index = '0;
      rsp_if.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_SLICE_COUNT;
      csr_write_data = '0;
      slice_count_reg = SLICE_COUNT_RST;
      stack_count_reg = STACK_COUNT_RST;
      radius_reg = SPHERE_RADIUS_RST;
      mismatch_count = 0;
      quiet_cycles = 0;
      ready_hold_left = 0;
      no_idle = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_random_spheres();
      test_backpressure();
      wait_drained();

      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
